>>> rtl/printf_conversion_spec_parser_top_macros.svh
// Assertion macros for the conversion-spec parser. All sample on i_clk and
// are disabled while i_rst_n is low.
`ifndef PRINTF_CONVERSION_SPEC_PARSER_TOP_MACROS_SVH
`define PRINTF_CONVERSION_SPEC_PARSER_TOP_MACROS_SVH

// Property holds in the same cycle.
`define PCSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Property holds in the cycle after the antecedent.
`define PCSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/pcsp_pkg.sv
`default_nettype none

package pcsp_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam logic [30:0] SAT_MAX = 31'h7FFF_FFFF;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_BIG_L = 8'h4C;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_J     = 8'h6A;
    localparam logic [7:0] CH_Z     = 8'h7A;

    // Flag bit positions
    localparam int unsigned FLAG_PLUS  = 0;
    localparam int unsigned FLAG_MINUS = 1;
    localparam int unsigned FLAG_ZERO  = 2;
    localparam int unsigned FLAG_SPACE = 3;
    localparam int unsigned FLAG_HASH  = 4;
    localparam int unsigned FLAG_BIG_L = 5;
    localparam int unsigned FLAG_T     = 6;

    // Length bit positions
    localparam int unsigned LEN_H  = 0;
    localparam int unsigned LEN_HH = 1;
    localparam int unsigned LEN_L  = 2;
    localparam int unsigned LEN_LL = 3;
    localparam int unsigned LEN_J  = 4;
    localparam int unsigned LEN_Z  = 5;

    typedef enum logic [3:0] {
        K_FLAG,
        K_ZERO,
        K_DIGIT,
        K_STAR,
        K_DOT,
        K_H,
        K_L,
        K_J,
        K_Z,
        K_OTHER
    } t_kind;

    typedef struct packed {
        logic [7:0]  ch;
        t_kind       kind;
        logic [3:0]  digit;
        logic [6:0]  flag;
        logic        star_neg;
        logic [30:0] star_val;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic pop;
        logic emit;
    } t_back_status;

endpackage

`default_nettype wire

>>> rtl/pcsp_front.sv
`default_nettype none

module pcsp_front (
    input  wire logic              i_in_valid,
    input  wire logic [7:0]        i_ch,
    input  wire logic signed [31:0] i_star_arg,
    input  wire logic              i_full,
    output logic                   o_in_ready,
    output logic                   o_push,
    output pcsp_pkg::t_item        o_item
);

    logic [31:0] neg_arg;

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;
    assign neg_arg    = 32'd0 - i_star_arg;

    always_comb begin
        o_item.ch       = i_ch;
        o_item.digit    = i_ch[3:0];
        o_item.flag     = '0;
        o_item.star_neg = i_star_arg[31];
        o_item.kind     = pcsp_pkg::K_OTHER;
        // magnitude of a negative star argument; the most negative value saturates
        if (i_star_arg[31]) begin
            o_item.star_val = neg_arg[31] ? pcsp_pkg::SAT_MAX : neg_arg[30:0];
        end else begin
            o_item.star_val = i_star_arg[30:0];
        end

        priority if (i_ch == pcsp_pkg::CH_PLUS) begin
            o_item.kind = pcsp_pkg::K_FLAG;
            o_item.flag[pcsp_pkg::FLAG_PLUS] = 1'b1;
        end else if (i_ch == pcsp_pkg::CH_MINUS) begin
            o_item.kind = pcsp_pkg::K_FLAG;
            o_item.flag[pcsp_pkg::FLAG_MINUS] = 1'b1;
        end else if (i_ch == pcsp_pkg::CH_SPACE) begin
            o_item.kind = pcsp_pkg::K_FLAG;
            o_item.flag[pcsp_pkg::FLAG_SPACE] = 1'b1;
        end else if (i_ch == pcsp_pkg::CH_HASH) begin
            o_item.kind = pcsp_pkg::K_FLAG;
            o_item.flag[pcsp_pkg::FLAG_HASH] = 1'b1;
        end else if (i_ch == pcsp_pkg::CH_BIG_L) begin
            o_item.kind = pcsp_pkg::K_FLAG;
            o_item.flag[pcsp_pkg::FLAG_BIG_L] = 1'b1;
        end else if (i_ch == pcsp_pkg::CH_T) begin
            o_item.kind = pcsp_pkg::K_FLAG;
            o_item.flag[pcsp_pkg::FLAG_T] = 1'b1;
        end else if (i_ch == pcsp_pkg::CH_ZERO) begin
            o_item.kind = pcsp_pkg::K_ZERO;
        end else if (i_ch > pcsp_pkg::CH_ZERO && i_ch <= pcsp_pkg::CH_NINE) begin
            o_item.kind = pcsp_pkg::K_DIGIT;
        end else if (i_ch == pcsp_pkg::CH_STAR) begin
            o_item.kind = pcsp_pkg::K_STAR;
        end else if (i_ch == pcsp_pkg::CH_DOT) begin
            o_item.kind = pcsp_pkg::K_DOT;
        end else if (i_ch == pcsp_pkg::CH_H) begin
            o_item.kind = pcsp_pkg::K_H;
        end else if (i_ch == pcsp_pkg::CH_L) begin
            o_item.kind = pcsp_pkg::K_L;
        end else if (i_ch == pcsp_pkg::CH_J) begin
            o_item.kind = pcsp_pkg::K_J;
        end else if (i_ch == pcsp_pkg::CH_Z) begin
            o_item.kind = pcsp_pkg::K_Z;
        end else begin
            o_item.kind = pcsp_pkg::K_OTHER;
        end
    end

endmodule

`default_nettype wire

>>> rtl/pcsp_queue.sv
`default_nettype none

module pcsp_queue #(
    parameter int unsigned DEPTH = pcsp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire pcsp_pkg::t_item i_item,
    input  wire logic           i_pop,
    output pcsp_pkg::t_item     o_item,
    output pcsp_pkg::t_q_status o_status
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    pcsp_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   n_wr_ptr;
    logic [PW-1:0]   n_rd_ptr;
    logic [CW-1:0]   n_count;

    assign o_item         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

>>> rtl/pcsp_back.sv
`default_nettype none

module pcsp_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_valid,
    input  wire pcsp_pkg::t_item    i_item,
    input  wire logic               i_out_ready,
    output pcsp_pkg::t_back_status  o_status,
    output logic                    o_out_valid,
    output logic [7:0]              o_conversion_char,
    output logic [6:0]              o_flag_bits,
    output logic [5:0]              o_length_bits,
    output logic [30:0]             o_field_width,
    output logic signed [31:0]      o_precision
);

    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_WDIG   = 6'b000010,
        PH_PSTART = 6'b000100,
        PH_PDIG   = 6'b001000,
        PH_HWAIT  = 6'b010000,
        PH_LWAIT  = 6'b100000
    } t_phase;

    t_phase      r_phase;
    logic [6:0]  r_flags;
    logic [5:0]  r_len;
    logic [30:0] r_width;
    logic [31:0] r_prec;
    logic        r_out_valid;
    logic [7:0]  r_out_ch;
    logic [6:0]  r_out_flags;
    logic [5:0]  r_out_len;
    logic [30:0] r_out_width;
    logic [31:0] r_out_prec;

    t_phase      n_phase;
    logic [6:0]  n_flags;
    logic [5:0]  n_len;
    logic [30:0] n_width;
    logic [31:0] n_prec;

    logic        handle;
    logic        emit;
    logic        is_dig;
    logic        out_free;
    logic        pop;
    logic [30:0] acc_in;
    logic [35:0] acc_sum;
    logic [30:0] acc_out;

    assign out_free = !r_out_valid || i_out_ready;
    assign pop      = i_q_valid && out_free;
    assign is_dig   = (i_item.kind == pcsp_pkg::K_DIGIT) || (i_item.kind == pcsp_pkg::K_ZERO);

    // Shared times-ten accumulate, saturating at the largest positive value
    assign acc_in  = (r_phase == PH_WDIG) ? r_width : r_prec[30:0];
    assign acc_sum = ({5'd0, acc_in} << 3) + ({5'd0, acc_in} << 1) + {32'd0, i_item.digit};
    assign acc_out = (acc_sum > {5'd0, pcsp_pkg::SAT_MAX}) ? pcsp_pkg::SAT_MAX : acc_sum[30:0];

    always_comb begin
        n_phase = r_phase;
        n_flags = r_flags;
        n_len   = r_len;
        n_width = r_width;
        n_prec  = r_prec;
        handle  = 1'b0;
        emit    = 1'b0;

        unique case (r_phase)
            PH_WDIG: begin
                if (is_dig) begin
                    n_width = acc_out;
                end else begin
                    n_phase = PH_IDLE;
                    handle  = 1'b1;
                end
            end
            PH_PSTART: begin
                n_phase = PH_IDLE;
                if (i_item.kind == pcsp_pkg::K_STAR) begin
                    n_prec = i_item.star_neg ? '1 : {1'b0, i_item.star_val};
                end else if (is_dig) begin
                    n_prec  = {28'd0, i_item.digit};
                    n_phase = PH_PDIG;
                end else begin
                    n_prec = '0;
                    handle = 1'b1;
                end
            end
            PH_PDIG: begin
                if (is_dig) begin
                    n_prec = {1'b0, acc_out};
                end else begin
                    n_phase = PH_IDLE;
                    handle  = 1'b1;
                end
            end
            PH_HWAIT: begin
                n_phase = PH_IDLE;
                if (i_item.kind == pcsp_pkg::K_H) begin
                    n_len[pcsp_pkg::LEN_HH] = 1'b1;
                end else begin
                    // copy the old h mark into hh, then toggle h
                    n_len[pcsp_pkg::LEN_HH] = r_len[pcsp_pkg::LEN_H];
                    n_len[pcsp_pkg::LEN_H]  = !r_len[pcsp_pkg::LEN_H];
                    handle = 1'b1;
                end
            end
            PH_LWAIT: begin
                n_phase = PH_IDLE;
                if (i_item.kind == pcsp_pkg::K_L) begin
                    n_len[pcsp_pkg::LEN_LL] = 1'b1;
                end else begin
                    n_len[pcsp_pkg::LEN_L] = 1'b1;
                    handle = 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                handle  = 1'b1;
            end
        endcase

        if (handle) begin
            unique case (i_item.kind)
                pcsp_pkg::K_FLAG:  n_flags = n_flags | i_item.flag;
                pcsp_pkg::K_ZERO:  n_flags[pcsp_pkg::FLAG_ZERO] = 1'b1;
                pcsp_pkg::K_STAR: begin
                    if (i_item.star_neg) begin
                        n_flags[pcsp_pkg::FLAG_MINUS] = 1'b1;
                    end
                    n_width = i_item.star_val;
                end
                pcsp_pkg::K_DOT:   n_phase = PH_PSTART;
                pcsp_pkg::K_H:     n_phase = PH_HWAIT;
                pcsp_pkg::K_L:     n_phase = PH_LWAIT;
                pcsp_pkg::K_J:     n_len[pcsp_pkg::LEN_J] = 1'b1;
                pcsp_pkg::K_Z:     n_len[pcsp_pkg::LEN_Z] = 1'b1;
                pcsp_pkg::K_DIGIT: begin
                    n_width = {27'd0, i_item.digit};
                    n_phase = PH_WDIG;
                end
                default:           emit = 1'b1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_flags     <= '0;
            r_len       <= '0;
            r_width     <= '0;
            r_prec      <= '1;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                if (emit) begin
                    r_phase <= PH_IDLE;
                    r_flags <= '0;
                    r_len   <= '0;
                    r_width <= '0;
                    r_prec  <= '1;
                end else begin
                    r_phase <= n_phase;
                    r_flags <= n_flags;
                    r_len   <= n_len;
                    r_width <= n_width;
                    r_prec  <= n_prec;
                end
            end
            if (pop && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && emit) begin
            r_out_ch    <= i_item.ch;
            r_out_flags <= n_flags;
            r_out_len   <= n_len;
            r_out_width <= n_width;
            r_out_prec  <= n_prec;
        end
    end

    assign o_status.pop    = pop;
    assign o_status.emit   = pop && emit;
    assign o_out_valid       = r_out_valid;
    assign o_conversion_char = r_out_ch;
    assign o_flag_bits       = r_out_flags;
    assign o_length_bits     = r_out_len;
    assign o_field_width     = r_out_width;
    assign o_precision       = $signed(r_out_prec);

endmodule

`default_nettype wire

>>> rtl/printf_conversion_spec_parser_top.sv
// Conversion-spec parser: feed the characters that follow a percent sign, one item
// per clock, each with its star argument. With QUEUE_DEPTH of two or more the
// parser sustains one item per cycle while results are taken; the saturating
// times-ten accumulate runs once per cycle in the back end while its output
// register is free. The item that ends the spec (any character that is not a flag,
// digit, star, dot or length mark, or NUL) enters the QUEUE_DEPTH-entry queue
// between classifier and executor; once popped, its result sits in the output
// register, with output valid high, until taken. Input ready drops only when that
// queue is full, which at that depth happens only while the consumer holds off.
`default_nettype none

`include "printf_conversion_spec_parser_top_macros.svh"

module printf_conversion_spec_parser_top #(
    parameter int unsigned QUEUE_DEPTH = pcsp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [7:0]         i_ch,
    input  wire logic signed [31:0] i_star_arg,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [7:0]              o_conversion_char,
    output logic [6:0]              o_flag_bits,
    output logic [5:0]              o_length_bits,
    output logic [30:0]             o_field_width,
    output logic signed [31:0]      o_precision
);

    logic                   q_push;
    pcsp_pkg::t_item        front_item;
    pcsp_pkg::t_item        q_item;
    pcsp_pkg::t_q_status    q_stat;
    pcsp_pkg::t_back_status back_stat;

    pcsp_front u_front (
        .i_in_valid (i_in_valid),
        .i_ch       (i_ch),
        .i_star_arg (i_star_arg),
        .i_full     (q_stat.full),
        .o_in_ready (o_in_ready),
        .o_push     (q_push),
        .o_item     (front_item)
    );

    pcsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_item   (front_item),
        .i_pop    (back_stat.pop),
        .o_item   (q_item),
        .o_status (q_stat)
    );

    pcsp_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (!q_stat.empty),
        .i_item            (q_item),
        .i_out_ready       (i_out_ready),
        .o_status          (back_stat),
        .o_out_valid       (o_out_valid),
        .o_conversion_char (o_conversion_char),
        .o_flag_bits       (o_flag_bits),
        .o_length_bits     (o_length_bits),
        .o_field_width     (o_field_width),
        .o_precision       (o_precision)
    );

    `PCSP_ASSERT_NOW(a_pop_not_empty, back_stat.pop, !q_stat.empty, "pop from empty queue")
    `PCSP_ASSERT_NOW(a_emit_slot_free, back_stat.emit, !o_out_valid || i_out_ready, "result overwritten")
    `PCSP_ASSERT_NEXT(a_push_lands, q_push && !back_stat.pop, !q_stat.empty, "pushed item lost")
    `PCSP_ASSERT_NEXT(a_emit_shows, back_stat.emit, o_out_valid, "emitted result not presented")

endmodule

`default_nettype wire
